>>> rtl/core/xcfr_pkg.sv
// Shared constants, reply table and control types for the frame receiver.
package xcfr_pkg;

    localparam int PAYLOAD_BYTES = 6;
    localparam int FRAME_W       = PAYLOAD_BYTES * 8;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int REPLY_LEN     = 6;
    localparam int IDX_W         = $clog2(REPLY_LEN);

    localparam logic [7:0] HEADER_BYTE = 8'hA7;
    localparam logic [7:0] REPLY_SYNC  = 8'hAA;
    localparam logic [7:0] REPLY_GOOD  = 8'h01;
    localparam logic [7:0] REPLY_BAD   = 8'h00;
    localparam logic [7:0] REPLY_TAIL0 = 8'hCC;
    localparam logic [7:0] REPLY_TAIL1 = 8'h33;
    localparam logic [7:0] REPLY_TAIL2 = 8'hC3;
    localparam logic [7:0] REPLY_TAIL3 = 8'h3C;

    localparam logic [IDX_W-1:0] REPLY_LAST_IDX = IDX_W'(REPLY_LEN - 1);

    // Request from the deframer to the reply stage, one per accepted item.
    typedef struct packed {
        logic load;  // an item was accepted this cycle
        logic send;  // it was a checksum byte: emit the full reply
        logic good;  // checksum matched
    } t_reply_req;

    // Byte of the acknowledge or reject reply at a given position.
    function automatic logic [7:0] reply_byte(input logic [IDX_W-1:0] idx,
                                              input logic good);
        logic [7:0] b;
        case (idx)
            3'd0:    b = REPLY_SYNC;
            3'd1:    b = good ? REPLY_GOOD : REPLY_BAD;
            3'd2:    b = REPLY_TAIL0;
            3'd3:    b = REPLY_TAIL1;
            3'd4:    b = REPLY_TAIL2;
            3'd5:    b = REPLY_TAIL3;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/xcfr_cell.sv
// One payload cell: holds a byte, hands it on along the shift chain, folds it into the checksum.
module xcfr_cell
    import xcfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_xor,
    output logic [7:0] o_byte,
    output logic [7:0] o_xor
);

    logic [7:0] r_byte;

    // Take the neighbour's byte on every payload shift.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_xor  = i_xor ^ r_byte;

endmodule

>>> rtl/core/xcfr_reply.sv
// Output register and reply sequencer: one status result or the six-byte reply.
module xcfr_reply
    import xcfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_reply_req i_req,
    input  logic       i_out_ready,
    output logic       o_idle,
    output logic       o_out_valid,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_tx_last
);

    logic             r_valid;
    logic             r_send;
    logic             r_good;
    logic [IDX_W-1:0] r_idx;
    logic             w_last;
    logic             w_take;

    assign w_last = !r_send || (r_idx == REPLY_LAST_IDX);
    assign w_take = r_valid && i_out_ready;
    assign o_idle = !r_valid || (i_out_ready && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_send  <= 1'b0;
            r_good  <= 1'b0;
            r_idx   <= '0;
        end else if (i_req.load) begin
            r_valid <= 1'b1;
            r_send  <= i_req.send;
            r_good  <= i_req.good;
            r_idx   <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_tx_valid  = r_send;
    assign o_tx_byte   = r_send ? reply_byte(r_idx, r_good) : 8'h00;
    assign o_tx_last   = w_last;

endmodule

>>> rtl/core/xor_checked_frame_receiver.sv
// Top level of the XOR-checked serial frame receiver.
// Takes one item per cycle unless stalled: a received byte (command 0) or a clear
// of the frame-ready flag (command 1). The receiver hunts for header 0xA7, then
// shifts six payload bytes through a chain of byte cells; each cell also
// folds its byte into the running XOR, so the checksum is ready when the
// seventh byte arrives. A matching checksum latches the 48-bit frame (first
// byte in the top bits), sets frame_ready and replies AA 01 CC 33 C3 3C; a
// mismatch replies AA 00 CC 33 C3 3C. Every other item yields one status
// result with tx_valid low and tx_last high. After a status item the next
// item is taken in the same cycle its result leaves; a checksum byte occupies
// the output register for six results, and input is held while the reply
// sequencer steps through its table. frame_ready and frame_data always show the
// state after the item being answered.
module xor_checked_frame_receiver
    import xcfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_tx_valid,
    output logic [7:0]         o_tx_byte,
    output logic               o_tx_last,
    output logic               o_frame_ready,
    output logic [FRAME_W-1:0] o_frame_data
);

    logic               r_in_frame;
    logic [CNT_W-1:0]   r_byte_count;
    logic [FRAME_W-1:0] r_latched;
    logic               r_ready_flag;

    logic               w_accept;
    logic               w_collect;
    logic               w_check;
    logic               w_shift;
    logic               w_match;
    logic               w_idle;
    t_reply_req         w_req;

    logic [7:0]         w_byte [PAYLOAD_BYTES];
    logic [7:0]         w_xor  [PAYLOAD_BYTES];
    logic [FRAME_W-1:0] w_frame;

    assign o_in_ready = w_idle;
    assign w_accept   = i_in_valid && w_idle;

    // A data byte inside a frame is payload until the count is full, then checksum.
    assign w_collect = !i_command && r_in_frame
                       && (r_byte_count != CNT_W'(PAYLOAD_BYTES));
    assign w_check   = !i_command && r_in_frame
                       && (r_byte_count == CNT_W'(PAYLOAD_BYTES));
    assign w_shift   = w_accept && w_collect;
    assign w_match   = (w_xor[PAYLOAD_BYTES-1] == i_rx_byte);

    // Payload chain: cell 0 takes the new byte, older bytes move up, so the
    // first byte of the frame ends in the last cell (the top of the frame).
    for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_cell
        logic [7:0] w_byte_in;
        logic [7:0] w_xor_in;
        if (k == 0) begin : g_head
            assign w_byte_in = i_rx_byte;
            assign w_xor_in  = 8'h00;
        end else begin : g_body
            assign w_byte_in = w_byte[k-1];
            assign w_xor_in  = w_xor[k-1];
        end
        xcfr_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(w_shift),
            .i_byte (w_byte_in),
            .i_xor  (w_xor_in),
            .o_byte (w_byte[k]),
            .o_xor  (w_xor[k])
        );
        assign w_frame[k*8 +: 8] = w_byte[k];
    end

    // Deframing state, latched frame and flag; all move only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_byte_count <= '0;
            r_latched    <= '0;
            r_ready_flag <= 1'b0;
        end else if (w_accept) begin
            if (i_command) begin
                r_ready_flag <= 1'b0;
            end else if (!r_in_frame) begin
                if (i_rx_byte == HEADER_BYTE) begin
                    r_in_frame   <= 1'b1;
                    r_byte_count <= '0;
                end
            end else if (w_collect) begin
                r_byte_count <= r_byte_count + 1'b1;
            end else begin
                // checksum byte: close the frame, keep it only if it checks
                r_in_frame   <= 1'b0;
                r_byte_count <= '0;
                if (w_match) begin
                    r_ready_flag <= 1'b1;
                    r_latched    <= w_frame;
                end
            end
        end
    end

    assign w_req.load = w_accept;
    assign w_req.send = w_check;
    assign w_req.good = w_match;

    xcfr_reply u_reply (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_out_ready(i_out_ready),
        .o_idle     (w_idle),
        .o_out_valid(o_out_valid),
        .o_tx_valid (o_tx_valid),
        .o_tx_byte  (o_tx_byte),
        .o_tx_last  (o_tx_last)
    );

    assign o_frame_ready = r_ready_flag;
    assign o_frame_data  = r_latched;

    // A good checksum sets the flag and latches the frame.
    a_good_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_check && w_match) |=> (r_ready_flag && !r_in_frame))
        else $error("good frame did not set frame_ready");

    // No item is taken while a reply is still mid-way.
    a_hold_mid_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tx_last) |-> !o_in_ready)
        else $error("item accepted during reply");

    // A status result carries no byte and closes its item.
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tx_valid) |-> (o_tx_last && (o_tx_byte == 8'h00)))
        else $error("malformed status result");

    // The payload count never runs past the frame length.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_W'(PAYLOAD_BYTES))
        else $error("payload count overrun");

endmodule
